>>> src/ecfc_pkg.sv
package ecfc_pkg;

    localparam int FRAME_W          = 16;
    localparam int DATA_W           = 14;
    localparam int IDX_W            = 3;
    localparam int CNT_W            = 4;
    localparam int DEF_MAX_ENCODERS = 8;
    localparam int MAX_LIMIT_W      = 7;   // holds counts up to 127
    localparam int FLAG_BIT         = 14;
    localparam int PAR_BIT          = 15;
    localparam int PERR_BIT         = 2;
    localparam int CERR_BIT         = 1;
    localparam int FERR_BIT         = 0;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

    typedef enum logic {
        CMD_BUILD = 1'b0,
        CMD_CHECK = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [IDX_W-1:0]   encoder_index;
        logic               flag_in;
        logic [DATA_W-1:0]  payload;
        logic [FRAME_W-1:0] rx_frame;
    } t_item;

    typedef struct packed {
        logic [FRAME_W-1:0] tx_frame;
        logic               frame_valid;
        logic               rx_flag;
        logic [DATA_W-1:0]  rx_data;
    } t_codec;

    typedef struct packed {
        logic               request_clear;
        logic               framing_error_bit;
        logic               command_error_bit;
        logic               parity_error_bit;
        logic [DATA_W-1:0]  angle;
        logic [DATA_W-1:0]  rx_data;
        logic               rx_flag;
        logic               frame_valid;
        logic [FRAME_W-1:0] tx_frame;
    } t_result;

    // even parity over bits 14..0
    function automatic logic parity15(input logic [FRAME_W-1:0] v);
        return ^v[PAR_BIT-1:0];
    endfunction

endpackage

>>> src/ecfc_codec.sv
module ecfc_codec (
    input  ecfc_pkg::t_item  i_item,
    output ecfc_pkg::t_codec o_codec
);
    import ecfc_pkg::*;

    logic [FRAME_W-1:0] body;

    always_comb begin
        body    = {1'b0, i_item.flag_in, i_item.payload};
        o_codec = '0;
        unique case (i_item.command)
            CMD_BUILD: begin
                o_codec.tx_frame = {parity15(body), body[PAR_BIT-1:0]};
            end
            CMD_CHECK: begin
                o_codec.frame_valid = i_item.rx_frame[PAR_BIT] == parity15(i_item.rx_frame);
                o_codec.rx_flag     = i_item.rx_frame[FLAG_BIT];
                o_codec.rx_data     = i_item.rx_frame[DATA_W-1:0];
            end
            default: o_codec = '0;
        endcase
    end

endmodule

>>> src/ecfc_tracker.sv
module ecfc_tracker #(
    parameter int MAX_ENCODERS = ecfc_pkg::DEF_MAX_ENCODERS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ecfc_pkg::CNT_W-1:0]     i_count,
    input  logic                           i_upd,
    input  logic                           i_check,
    input  logic [ecfc_pkg::IDX_W-1:0]     i_idx,
    input  logic                           i_valid,
    input  logic [ecfc_pkg::DATA_W-1:0]    i_data,
    output logic [ecfc_pkg::DATA_W-1:0]    o_angle,
    output logic                           o_request_clear
);
    import ecfc_pkg::*;

    // only indexes reachable through the index field get storage
    localparam int STORE_DEPTH = (MAX_ENCODERS < (1 << IDX_W)) ? MAX_ENCODERS : (1 << IDX_W);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [MAX_LIMIT_W-1:0] MAX_V = MAX_LIMIT_W'(MAX_ENCODERS);

    logic [DATA_W-1:0]      r_store [STORE_DEPTH];
    logic                   r_pass_ok;
    logic                   n_pass_ok;
    logic                   in_store;
    logic [ADDR_W-1:0]      addr;
    logic [MAX_LIMIT_W-1:0] eff_count;
    logic                   last_enc;
    logic                   wr_en;
    logic                   pass_and;

    always_comb begin
        in_store = MAX_LIMIT_W'(i_idx) < MAX_V;
        addr     = in_store ? i_idx[ADDR_W-1:0] : '0;
        wr_en    = i_upd && i_check && i_valid && in_store;

        // zero means one encoder, above the limit clamps to the limit
        priority if (i_count == '0) begin
            eff_count = MAX_LIMIT_W'(1);
        end else if (MAX_LIMIT_W'(i_count) > MAX_V) begin
            eff_count = MAX_V;
        end else begin
            eff_count = MAX_LIMIT_W'(i_count);
        end
        last_enc = MAX_LIMIT_W'(i_idx) == (eff_count - MAX_LIMIT_W'(1));

        pass_and        = r_pass_ok && i_valid;
        o_request_clear = i_check && last_enc && !pass_and;
        n_pass_ok       = r_pass_ok;
        if (i_upd && i_check) begin
            n_pass_ok = last_enc ? 1'b1 : pass_and;
        end

        // angle after this item: freshly written data wins over the stored value
        if (!in_store) begin
            o_angle = '0;
        end else if (i_check && i_valid) begin
            o_angle = i_data;
        end else begin
            o_angle = r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_ok <= 1'b1;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_pass_ok <= n_pass_ok;
            if (wr_en) begin
                r_store[addr] <= i_data;
            end
        end
    end

    a_rearm_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && o_request_clear) |=> r_pass_ok)
        else $error("pass tracker not rearmed after clear request");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd |=> $stable(r_pass_ok))
        else $error("pass tracker changed without an item");

    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && i_check && !i_valid && !last_enc) |=> !r_pass_ok)
        else $error("failed frame not recorded in pass");

endmodule

>>> src/encoder_spi_frame_checker.sv
// Builds and checks 16-bit encoder frames (14 data bits, flag in bit 14, even parity
// in bit 15). An item can be accepted every cycle. Each item passes through the input
// register, then the result register, whose output is the result. The input stalls
// only while both registers hold items and the result side does not take the waiting
// result. Check items update the pass tracker, and those with good parity also the
// per-encoder angle table, as they move into the result register; request_clear is
// raised on the frame of the last encoder of the chain if any frame of the pass failed
// parity. encoder_count may only be written while no item is in flight.
module encoder_spi_frame_checker #(
    parameter int MAX_ENCODERS = ecfc_pkg::DEF_MAX_ENCODERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ecfc_pkg::CNT_W-1:0]    i_cfg_wr_data,   // encoder_count
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [2:0] encoder_index, [3] flag_in, [17:4] payload, [33:18] rx_frame, rest zero
    input  logic [39:0]                   i_s_axis_tdata,
    input  logic                          i_s_axis_tuser,  // [0] command
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] tx_frame, [16] frame_valid, [17] rx_flag, [31:18] rx_data, [45:32] angle,
    // [46] parity_error_bit, [47] command_error_bit, [48] framing_error_bit,
    // [49] request_clear, rest zero
    output logic [55:0]                   o_m_axis_tdata
);
    import ecfc_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             r_s1_valid;
    t_item            r_s1_item;
    logic             r_out_valid;
    t_result          r_out;
    t_item            in_item;
    t_codec           codec;
    t_result          n_out;
    logic             advance;
    logic [DATA_W-1:0] angle;
    logic             req_clear;

    assign advance         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || advance;

    always_comb begin
        in_item.command       = t_cmd'(i_s_axis_tuser);
        in_item.encoder_index = i_s_axis_tdata[2:0];
        in_item.flag_in       = i_s_axis_tdata[3];
        in_item.payload       = i_s_axis_tdata[17:4];
        in_item.rx_frame      = i_s_axis_tdata[33:18];
    end

    ecfc_codec u_codec (
        .i_item  (r_s1_item),
        .o_codec (codec)
    );

    ecfc_tracker #(
        .MAX_ENCODERS (MAX_ENCODERS)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_count         (r_count),
        .i_upd           (advance),
        .i_check         (r_s1_item.command == CMD_CHECK),
        .i_idx           (r_s1_item.encoder_index),
        .i_valid         (codec.frame_valid),
        .i_data          (codec.rx_data),
        .o_angle         (angle),
        .o_request_clear (req_clear)
    );

    always_comb begin
        n_out.tx_frame          = codec.tx_frame;
        n_out.frame_valid       = codec.frame_valid;
        n_out.rx_flag           = codec.rx_flag;
        n_out.rx_data           = codec.rx_data;
        n_out.angle             = angle;
        n_out.parity_error_bit  = codec.rx_data[PERR_BIT];
        n_out.command_error_bit = codec.rx_data[CERR_BIT];
        n_out.framing_error_bit = codec.rx_data[FERR_BIT];
        n_out.request_clear     = req_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_s1_item <= in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out};

endmodule
